>>> sv/rsc_pkg.sv
// Shared types, codes and sizes for the RPN stack calculator.
// No dependencies; every other file but rsc_ram imports this package.
package rsc_pkg;

    // Q16.16 data path
    localparam int Q_W       = 32;
    localparam int FRAC_W    = 16;

    // Operand stack sizing
    localparam int STACK_DEPTH = 64;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    // Input opcodes
    localparam int OPC_W = 3;
    localparam logic [OPC_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OPC_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OPC_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OPC_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OPC_W-1:0] OP_DIV  = 3'd4;

    // Command kinds after classification
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] K_PUSH    = 3'd0;
    localparam logic [KIND_W-1:0] K_ADD     = 3'd1;
    localparam logic [KIND_W-1:0] K_SUB     = 3'd2;
    localparam logic [KIND_W-1:0] K_MUL     = 3'd3;
    localparam logic [KIND_W-1:0] K_DIV     = 3'd4;
    localparam logic [KIND_W-1:0] K_UNKNOWN = 3'd5;

    // Result status codes
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_MISSING = 3'd1;
    localparam logic [ST_W-1:0] ST_DIVZERO = 3'd2;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

    // Saturation limits
    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Command queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Divider: quotient of (left << 16) / right, two bits per cycle
    localparam int DIV_QW    = Q_W + FRAC_W;
    localparam int DIV_BITS  = 2;
    localparam int DIV_ITERS = DIV_QW / DIV_BITS;
    localparam int DIV_CW    = $clog2(DIV_ITERS + 1);

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [Q_W-1:0]   operand;
    } t_cmd;

    function automatic logic signed [Q_W-1:0] sat_sum(input logic signed [Q_W:0] v);
        if (v[Q_W] != v[Q_W-1]) begin
            return v[Q_W] ? Q_MIN : Q_MAX;
        end
        return v[Q_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] sat_wide(input logic signed [DIV_QW-1:0] v);
        if (v[DIV_QW-1:Q_W-1] != {(DIV_QW-Q_W+1){v[DIV_QW-1]}}) begin
            return v[DIV_QW-1] ? Q_MIN : Q_MAX;
        end
        return v[Q_W-1:0];
    endfunction

endpackage

>>> sv/rsc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> sv/rsc_fifo.sv
// Short command queue between the front and the back of the calculator.
// Depends on rsc_pkg for the command type and queue depth.
module rsc_fifo
    import rsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/rsc_front.sv
// Input stage: takes requests, classifies the opcode and hands commands to the queue.
// Depends on rsc_pkg for opcodes, command kinds and the command type.
module rsc_front
    import rsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [OPC_W-1:0]      i_opcode,
    input  logic signed [Q_W-1:0] i_operand,
    output logic                  o_cmd_valid,
    output t_cmd                  o_cmd,
    input  logic                  i_cmd_full
);

    logic              r_valid;
    t_cmd              r_cmd;
    logic [KIND_W-1:0] kind;
    logic              accept;

    always_comb begin
        unique case (i_opcode)
            OP_PUSH: kind = K_PUSH;
            OP_ADD:  kind = K_ADD;
            OP_SUB:  kind = K_SUB;
            OP_MUL:  kind = K_MUL;
            OP_DIV:  kind = K_DIV;
            default: kind = K_UNKNOWN;
        endcase
    end

    assign o_stall     = r_valid && i_cmd_full;
    assign accept      = i_valid && !o_stall;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.kind    <= kind;
            r_cmd.operand <= i_operand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_cmd_full) begin
            r_valid <= 1'b0;
        end
    end

endmodule

>>> sv/rsc_div.sv
// Iterative Q16.16 divider: (left << 16) / right, truncated toward zero, saturated.
// Depends on rsc_pkg for widths, iteration count and limits.
module rsc_div
    import rsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [Q_W-1:0] i_left,
    input  logic signed [Q_W-1:0] i_right,
    output logic                  o_done,
    output logic signed [Q_W-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [Q_W:0]      r_rem;
    logic [DIV_QW-1:0] r_quo;
    logic [Q_W-1:0]    r_dvs;
    logic              r_neg;
    logic [Q_W:0]      n_rem;
    logic [DIV_QW-1:0] n_quo;
    logic [Q_W-1:0]    left_mag;
    logic [Q_W-1:0]    right_mag;
    logic              too_big;

    assign left_mag  = i_left[Q_W-1]  ? Q_W'(-i_left)  : i_left;
    assign right_mag = i_right[Q_W-1] ? Q_W'(-i_right) : i_right;

    // Restoring division, DIV_BITS quotient bits per cycle.
    always_comb begin
        logic [Q_W:0] trial;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial = {n_rem[Q_W-1:0], n_quo[DIV_QW-1]};
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = trial - {1'b0, r_dvs};
                n_quo = {n_quo[DIV_QW-2:0], 1'b1};
            end else begin
                n_rem = trial;
                n_quo = {n_quo[DIV_QW-2:0], 1'b0};
            end
        end
    end

    // A negative result may reach one step further than a positive one.
    always_comb begin
        if (r_neg) begin
            too_big = (r_quo[DIV_QW-1:Q_W] != '0) ||
                      (r_quo[Q_W-1] && (r_quo[Q_W-2:0] != '0));
            o_quot  = too_big ? Q_MIN : Q_W'(-r_quo[Q_W-1:0]);
        end else begin
            too_big = (r_quo[DIV_QW-1:Q_W-1] != '0);
            o_quot  = too_big ? Q_MAX : r_quo[Q_W-1:0];
        end
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {left_mag, {FRAC_W{1'b0}}};
            r_dvs <= right_mag;
            r_neg <= i_left[Q_W-1] ^ i_right[Q_W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_ITERS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

>>> sv/rsc_back.sv
// Execution stage: keeps the operand stack, carries out commands, holds the result.
// Depends on rsc_pkg, rsc_ram (stack below the top) and rsc_div.
module rsc_back
    import rsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_cmd                  i_q_cmd,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [Q_W-1:0] o_top_value,
    output logic [SP_W-1:0]       o_stack_depth,
    output logic [ST_W-1:0]       o_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [1:0]               r_state,  n_state;
    logic [SP_W-1:0]          r_sp,     n_sp;
    logic signed [Q_W-1:0]    r_top,    n_top;
    logic [KIND_W-1:0]        r_kind,   n_kind;
    logic signed [2*Q_W-1:0]  r_prod,   n_prod;
    logic                     r_out_valid, n_out_valid;
    logic signed [Q_W-1:0]    r_out_top,   n_out_top;
    logic [SP_W-1:0]          r_out_depth, n_out_depth;
    logic [ST_W-1:0]          r_out_status, n_out_status;

    logic                     out_free;
    logic                     start;
    logic [SP_W-1:0]          sp_m1;
    logic [SP_W-1:0]          sp_m2;
    logic                     ram_we;
    logic                     ram_re;
    logic signed [Q_W-1:0]    left;
    logic signed [2*Q_W-1:0]  mul_full;
    logic                     div_start;
    logic                     div_done;
    logic signed [Q_W-1:0]    div_quot;
    logic                     finish;
    logic signed [Q_W-1:0]    res;

    // The top of the stack lives in r_top; the RAM holds the entries below it.
    assign sp_m1    = r_sp - 1'b1;
    assign sp_m2    = r_sp - 2'd2;
    assign out_free = !r_out_valid || !i_stall;
    assign start    = (r_state == S_IDLE) && i_q_valid && out_free;
    assign o_q_pop  = start;
    assign mul_full = left * r_top;

    rsc_ram #(
        .WIDTH (Q_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (sp_m1[STACK_AW-1:0]),
        .i_wdata (r_top),
        .i_re    (ram_re),
        .i_raddr (sp_m2[STACK_AW-1:0]),
        .o_rdata (left)
    );

    rsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_left  (left),
        .i_right (r_top),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state      = r_state;
        n_sp         = r_sp;
        n_top        = r_top;
        n_kind       = r_kind;
        n_prod       = r_prod;
        n_out_valid  = r_out_valid && i_stall;
        n_out_top    = r_out_top;
        n_out_depth  = r_out_depth;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        div_start    = 1'b0;
        finish       = 1'b0;
        res          = r_top;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind       = i_q_cmd.kind;
                    n_out_valid  = 1'b1;
                    n_out_top    = (r_sp != '0) ? r_top : '0;
                    n_out_depth  = r_sp;
                    n_out_status = ST_OK;
                    unique case (i_q_cmd.kind) inside
                        K_PUSH: begin
                            if (r_sp == SP_W'(STACK_DEPTH)) begin
                                n_out_status = ST_FULL;
                            end else begin
                                ram_we      = (r_sp != '0);
                                n_top       = i_q_cmd.operand;
                                n_sp        = r_sp + 1'b1;
                                n_out_top   = i_q_cmd.operand;
                                n_out_depth = r_sp + 1'b1;
                            end
                        end
                        K_ADD, K_SUB, K_MUL, K_DIV: begin
                            if (r_sp == '0) begin
                                n_out_status = ST_MISSING;
                            end else if (r_sp == SP_W'(1)) begin
                                // A lone operand is dropped.
                                n_sp         = '0;
                                n_out_top    = '0;
                                n_out_depth  = '0;
                                n_out_status = ST_MISSING;
                            end else if ((i_q_cmd.kind == K_DIV) && (r_top == '0)) begin
                                n_out_status = ST_DIVZERO;
                            end else begin
                                n_out_valid = 1'b0;
                                ram_re      = 1'b1;
                                n_state     = S_READ;
                            end
                        end
                        default: begin
                            n_out_status = ST_UNKNOWN;
                        end
                    endcase
                end
            end
            S_READ: begin
                unique case (r_kind)
                    K_ADD: begin
                        finish = 1'b1;
                        res    = sat_sum((Q_W+1)'(left) + (Q_W+1)'(r_top));
                    end
                    K_SUB: begin
                        finish = 1'b1;
                        res    = sat_sum((Q_W+1)'(left) - (Q_W+1)'(r_top));
                    end
                    K_MUL: begin
                        n_prod  = mul_full;
                        n_state = S_MUL;
                    end
                    K_DIV: begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_MUL: begin
                // An arithmetic shift of the product rounds toward minus infinity.
                finish = 1'b1;
                res    = sat_wide(r_prod[2*Q_W-1:FRAC_W]);
            end
            S_DIV: begin
                if (div_done) begin
                    finish = 1'b1;
                    res    = div_quot;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            n_state      = S_IDLE;
            n_top        = res;
            n_sp         = sp_m1;
            n_out_valid  = 1'b1;
            n_out_top    = res;
            n_out_depth  = sp_m1;
            n_out_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_kind       <= n_kind;
        r_prod       <= n_prod;
        r_out_top    <= n_out_top;
        r_out_depth  <= n_out_depth;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_top_value   = r_out_top;
    assign o_stack_depth = r_out_depth;
    assign o_status      = r_out_status;

endmodule

>>> sv/rpn_stack_calculator_top.sv
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_stall   i_opcode[2:0], i_operand[31:0]
// result    out        o_valid / i_stall   o_top_value[31:0], o_stack_depth[6:0], o_status[2:0]
//
// Push, unrecognized and short-stack requests end in the idle state of the execution stage;
// add and subtract pass the read state too, multiply the read and multiply states (one 32x32
// multiplier, registered product), divide the read and divide states, where the divider retires
// two quotient bits per cycle over 24 iterations; requests are carried out one at a time.
// Reset is synchronous and active low and leaves the stack empty.
// A two-entry queue lets requests be taken while a result waits under i_stall.
// Top level of the RPN stack calculator; depends on rsc_pkg, rsc_front, rsc_fifo, rsc_back.
module rpn_stack_calculator_top
    import rsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [OPC_W-1:0]      i_opcode,
    input  logic signed [Q_W-1:0] i_operand,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [Q_W-1:0] o_top_value,
    output logic [SP_W-1:0]       o_stack_depth,
    output logic [ST_W-1:0]       o_status
);

    logic fr_valid;
    t_cmd fr_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    rsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_operand   (i_operand),
        .o_cmd_valid (fr_valid),
        .o_cmd       (fr_cmd),
        .i_cmd_full  (q_full)
    );

    rsc_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_cmd   (fr_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    rsc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_top_value   (o_top_value),
        .o_stack_depth (o_stack_depth),
        .o_status      (o_status)
    );

endmodule

>>> sv/rsc_checker.sv
// Port-level checks for the RPN stack calculator, bound to the top level.
// Depends on rsc_pkg for status codes and the stack depth.
module rsc_checker
    import rsc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic signed [Q_W-1:0] o_top_value,
    input logic [SP_W-1:0]       o_stack_depth,
    input logic [ST_W-1:0]       o_status
);

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_top_value) &&
        $stable(o_stack_depth) && $stable(o_status))
        else $error("result changed while stalled");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stack_depth <= SP_W'(STACK_DEPTH))
        else $error("stack depth out of range");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_stack_depth == '0) |-> o_top_value == '0)
        else $error("empty stack shows a nonzero top");

    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> o_stack_depth == SP_W'(STACK_DEPTH))
        else $error("stack full reported below full depth");

    // Missing operands always leave the stack empty.
    a_missing_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_MISSING) |-> o_stack_depth == '0)
        else $error("missing operands with values left on the stack");

endmodule

bind rpn_stack_calculator_top rsc_checker u_checker (.*);
